/* src/stable_sorted_priority_queue_unit_defines.svh */
// assertion macros for the checker file
`ifndef STABLE_SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk and muted while rst_n is low
`define SSPQ_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk and muted while rst_n is low
`define SSPQ_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sspq_pkg.sv */
// types and constants of the stable sorted priority queue
package sspq_pkg;

    localparam int CODE_W = 16;
    localparam int PRIO_W = 8;
    localparam int OCC_W  = 5;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_LIST   = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [CODE_W-1:0] item_code;
        logic [PRIO_W-1:0] item_priority;
    } cmd_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] out_code;
        logic [PRIO_W-1:0] out_priority;
        logic [1:0]        status;
        logic              last;
        logic [OCC_W-1:0]  occupancy;
    } res_item_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic              sorted;
        logic [CODE_W-1:0] code;
        logic [PRIO_W-1:0] prio;
    } cell_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } ctrl_state_t;

endpackage

/* src/sspq_cell.sv */
// one slot of the queue: holds an entry and trades it with its neighbors
module sspq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  sspq_pkg::cell_cmd_t cmd,
    input  sspq_pkg::entry_t    left,
    input  sspq_pkg::entry_t    right,
    input  sspq_pkg::entry_t    head,
    input  logic               found_in,
    output sspq_pkg::entry_t    entry,
    output logic               found_out
);
    import sspq_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;
    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;
    logic              hit;
    logic              tail;

    assign entry = '{valid: valid_reg, code: code_reg, prio: prio_reg};

    // first free slot, or for a sorted insert the first strictly greater one
    assign hit       = !valid_reg || (cmd.sorted && (prio_reg > cmd.prio));
    assign found_out = found_in || hit;
    assign tail      = valid_reg && !right.valid;

    always_comb
    begin
        valid_next = valid_reg;
        code_next  = code_reg;
        prio_next  = prio_reg;
        unique case (cmd.op)
            OP_HOLD:
            begin
            end
            OP_INSERT:
            begin
                if (found_in)
                begin
                    valid_next = left.valid;
                    code_next  = left.code;
                    prio_next  = left.prio;
                end
                else if (hit)
                begin
                    valid_next = 1'b1;
                    code_next  = cmd.code;
                    prio_next  = cmd.prio;
                end
            end
            OP_REMOVE:
            begin
                valid_next = right.valid;
                code_next  = right.code;
                prio_next  = right.prio;
            end
            OP_ROTATE:
            begin
                // the rear slot takes the front entry, the rest move forward
                if (tail)
                begin
                    valid_next = head.valid;
                    code_next  = head.code;
                    prio_next  = head.prio;
                end
                else
                begin
                    valid_next = right.valid;
                    code_next  = right.code;
                    prio_next  = right.prio;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        prio_reg <= prio_next;
    end

endmodule

/* src/stable_sorted_priority_queue_unit.sv */
// top level of the stable sorted priority queue: cell chain and control
//
//  channel | direction | payload    | handshake
//  cmd     | in        | cmd_item_t | cmd_valid / cmd_stall
//  res     | out       | res_item_t | res_valid / res_stall
//
// insert, append and remove each give one result
// a list of n entries gives n results, one a cycle while the output is not stalled, by rotating the chain
// no new item is taken while a list runs or a result waits in a stalled slot
// the result sits in an output register, valid in the cycle after the item is taken
// reset empties the queue at once; no clearing pass
module stable_sorted_priority_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  sspq_pkg::cmd_item_t cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output sspq_pkg::res_item_t res
);
    import sspq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    entry_t      cell_q [DEPTH];
    entry_t      left_e [DEPTH];
    entry_t      right_e[DEPTH];
    logic [DEPTH:0] found;
    cell_cmd_t   cell_cmd;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] rem_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    res_item_t   res_reg;
    res_item_t   res_next;

    logic        out_free;
    logic        accept;

    assign found[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign left_e[i] = '0;
        end
        else
        begin : g_mid
            assign left_e[i] = cell_q[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_e[i] = '0;
        end
        else
        begin : g_inner
            assign right_e[i] = cell_q[i+1];
        end

        sspq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cell_cmd),
            .left      (left_e[i]),
            .right     (right_e[i]),
            .head      (cell_q[0]),
            .found_in  (found[i]),
            .entry     (cell_q[i]),
            .found_out (found[i+1])
        );
    end

    assign out_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept    = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_next        = res_reg;
        cell_cmd.op     = OP_HOLD;
        cell_cmd.sorted = (cmd.mode == MODE_INSERT);
        cell_cmd.code   = cmd.item_code;
        cell_cmd.prio   = cmd.item_priority;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_valid_next        = 1'b1;
                    res_next.out_code     = '0;
                    res_next.out_priority = '0;
                    res_next.status       = STATUS_OK;
                    res_next.last         = 1'b1;
                    unique case (cmd.mode)
                        MODE_INSERT, MODE_APPEND:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                res_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                cell_cmd.op = OP_INSERT;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = STATUS_EMPTY;
                            end
                            else
                            begin
                                res_next.out_code     = cell_q[0].code;
                                res_next.out_priority = cell_q[0].prio;
                                cell_cmd.op           = OP_REMOVE;
                                count_next            = count_reg - 1'b1;
                            end
                        end
                        MODE_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = STATUS_EMPTY;
                            end
                            else
                            begin
                                res_next.out_code     = cell_q[0].code;
                                res_next.out_priority = cell_q[0].prio;
                                res_next.last         = (count_reg == CW'(1));
                                cell_cmd.op           = OP_ROTATE;
                                rem_next              = count_reg - 1'b1;
                                if (count_reg != CW'(1))
                                begin
                                    state_next = ST_LIST;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    res_next.occupancy = OCC_W'(count_next);
                end
            end
            ST_LIST:
            begin
                if (out_free)
                begin
                    res_valid_next        = 1'b1;
                    res_next.out_code     = cell_q[0].code;
                    res_next.out_priority = cell_q[0].prio;
                    res_next.status       = STATUS_OK;
                    res_next.last         = (rem_reg == CW'(1));
                    res_next.occupancy    = OCC_W'(count_reg);
                    cell_cmd.op           = OP_ROTATE;
                    rem_next              = rem_reg - 1'b1;
                    if (rem_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

/* src/sspq_checker.sv */
// port-level checks on the stable sorted priority queue, bound to the top level
`include "stable_sorted_priority_queue_unit_defines.svh"

module sspq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_stall,
    input logic                res_valid,
    input logic                res_stall,
    input sspq_pkg::res_item_t res
);
    import sspq_pkg::*;

    `SSPQ_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "result item changed while stalled")
    `SSPQ_ASSERT_IMP(a_full_single, res_valid && (res.status == STATUS_FULL), res.last && (res.out_code == '0) && (res.out_priority == '0), "refused insert gave a bad result")
    `SSPQ_ASSERT_IMP(a_empty_single, res_valid && (res.status == STATUS_EMPTY), res.last && (res.occupancy == '0), "empty status with entries left")
    `SSPQ_ASSERT_IMP(a_list_busy, res_valid && !res.last, cmd_stall, "new item taken in the middle of a list")

endmodule

bind stable_sorted_priority_queue_unit sspq_checker u_sspq_checker (.*);

/* tb/tb_stable_sorted_priority_queue_unit.sv */
// testbench for the stable sorted priority queue unit
`timescale 1ns / 100ps

module tb_stable_sorted_priority_queue_unit;
    import sspq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int CLK_PERIOD   = 10;
    localparam int ITEM_TARGET  = 410;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_CAP    = 30;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_item_t cmd = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res;

    cmd_item_t cmd_backlog[$];
    res_item_t awaited_replies[$];

    // shadow copy of the stored entries, front at index 0
    logic [CODE_W-1:0] shadow_code[QUEUE_DEPTH];
    logic [PRIO_W-1:0] shadow_prio[QUEUE_DEPTH];
    int                shadow_fill = 0;

    // occupancy as the stimulus plan sees it
    int plan_fill = 0;

    int unsigned send_wait = 0;
    int unsigned rx_wait = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    int          cmds_taken = 0;
    int          results_taken = 0;
    int          idle_cycles = 0;
    int          mismatches = 0;

    stable_sorted_priority_queue_unit #(
        .DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
        begin
            $display("mismatch at result %0d: %s got %h want %h",
                     results_taken, what, got, want);
        end
    endtask

    task automatic push_reply(input logic [CODE_W-1:0] code, input logic [PRIO_W-1:0] prio,
                              input logic [1:0] status, input logic last);
        res_item_t r;
        r.out_code     = code;
        r.out_priority = prio;
        r.status       = status;
        r.last         = last;
        r.occupancy    = shadow_fill[OCC_W-1:0];
        awaited_replies.push_back(r);
    endtask

    // apply one accepted item to the shadow queue and queue up its replies
    task automatic shadow_queue_op(input cmd_item_t c);
        int pos;
        int i;
        logic [CODE_W-1:0] front_code;
        logic [PRIO_W-1:0] front_prio;
        if (c.mode == MODE_INSERT || c.mode == MODE_APPEND)
        begin
            if (shadow_fill >= QUEUE_DEPTH)
            begin
                push_reply('0, '0, STATUS_FULL, 1'b1);
            end
            else
            begin
                pos = shadow_fill;
                // stable: go before the first strictly greater priority
                if (c.mode == MODE_INSERT)
                begin
                    for (i = shadow_fill - 1; i >= 0; i--)
                    begin
                        if (shadow_prio[i] > c.item_priority)
                            pos = i;
                    end
                end
                for (i = shadow_fill; i > pos; i--)
                begin
                    shadow_code[i] = shadow_code[i-1];
                    shadow_prio[i] = shadow_prio[i-1];
                end
                shadow_code[pos] = c.item_code;
                shadow_prio[pos] = c.item_priority;
                shadow_fill++;
                push_reply('0, '0, STATUS_OK, 1'b1);
            end
        end
        else if (shadow_fill == 0)
        begin
            push_reply('0, '0, STATUS_EMPTY, 1'b1);
        end
        else if (c.mode == MODE_REMOVE)
        begin
            front_code = shadow_code[0];
            front_prio = shadow_prio[0];
            for (i = 1; i < shadow_fill; i++)
            begin
                shadow_code[i-1] = shadow_code[i];
                shadow_prio[i-1] = shadow_prio[i];
            end
            shadow_fill--;
            push_reply(front_code, front_prio, STATUS_OK, 1'b1);
        end
        else
        begin
            for (i = 0; i < shadow_fill; i++)
                push_reply(shadow_code[i], shadow_prio[i], STATUS_OK, i == shadow_fill - 1);
        end
    endtask

    task automatic check_result(input res_item_t got);
        res_item_t want;
        if (awaited_replies.size() == 0)
        begin
            report_mismatch("result with nothing pending", got, '0);
            return;
        end
        want = awaited_replies.pop_front();
        if (got.out_code !== want.out_code)
            report_mismatch("out_code", 32'(got.out_code), 32'(want.out_code));
        if (got.out_priority !== want.out_priority)
            report_mismatch("out_priority", 32'(got.out_priority), 32'(want.out_priority));
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.last !== want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
        if (got.occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(got.occupancy), 32'(want.occupancy));
    endtask

    task automatic add_cmd(input logic [1:0] mode, input logic [CODE_W-1:0] code,
                           input logic [PRIO_W-1:0] prio);
        cmd_item_t c;
        c.mode          = mode;
        c.item_code     = code;
        c.item_priority = prio;
        cmd_backlog.push_back(c);
        if ((mode == MODE_INSERT || mode == MODE_APPEND) && plan_fill < QUEUE_DEPTH)
            plan_fill++;
        else if (mode == MODE_REMOVE && plan_fill > 0)
            plan_fill--;
    endtask

    // mix of tie-heavy, extreme and spread-out priorities
    function automatic logic [PRIO_W-1:0] rand_prio();
        case ($urandom_range(0, 3))
            0: rand_prio = PRIO_W'($urandom_range(0, 255));
            1: rand_prio = PRIO_W'($urandom_range(0, 3) * 64);
            2: rand_prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: rand_prio = PRIO_W'($urandom_range(120, 135));
        endcase
    endfunction

    function automatic logic [CODE_W-1:0] rand_code();
        rand_code = CODE_W'($urandom_range(0, 65535));
    endfunction

    task automatic add_random_store();
        add_cmd($urandom_range(0, 3) == 0 ? MODE_APPEND : MODE_INSERT, rand_code(), rand_prio());
    endtask

    task automatic build_stimulus();
        int i;
        int target;
        int r;
        // empty queue cases, then extremes and ties
        add_cmd(MODE_LIST,   16'h0000, 8'h00);
        add_cmd(MODE_REMOVE, 16'hFFFF, 8'hFF);
        add_cmd(MODE_INSERT, 16'hFFFF, 8'hFF);
        add_cmd(MODE_INSERT, 16'h0000, 8'h00);
        add_cmd(MODE_INSERT, 16'h1234, 8'h80);
        add_cmd(MODE_INSERT, 16'h1235, 8'h80);
        add_cmd(MODE_APPEND, 16'hAAAA, 8'h00);
        add_cmd(MODE_INSERT, 16'h5555, 8'hFF);
        add_cmd(MODE_INSERT, 16'h8001, 8'h01);
        add_cmd(MODE_LIST,   16'h0000, 8'h00);
        add_cmd(MODE_REMOVE, 16'h0000, 8'h00);
        for (i = 0; plan_fill < QUEUE_DEPTH; i++)
            add_cmd(i % 3 == 2 ? MODE_APPEND : MODE_INSERT,
                    {i[7:0], ~i[7:0]}, i[0] ? 8'h7F : 8'h80);
        // full store refuses both kinds of store
        add_cmd(MODE_INSERT, 16'hBEEF, 8'h00);
        add_cmd(MODE_APPEND, 16'hCAFE, 8'hFF);
        add_cmd(MODE_LIST,   16'h0000, 8'h00);
        add_cmd(MODE_REMOVE, 16'h0000, 8'h00);

        while (cmd_backlog.size() < ITEM_TARGET)
        begin
            r = $urandom_range(0, 5);
            if (r <= 2)
            begin
                target = ($urandom_range(0, 2) == 0) ? QUEUE_DEPTH
                                                     : $urandom_range(plan_fill, QUEUE_DEPTH);
                while (plan_fill < target)
                begin
                    case ($urandom_range(0, 9))
                        0: add_cmd(MODE_LIST, rand_code(), rand_prio());
                        1: add_cmd(MODE_REMOVE, rand_code(), rand_prio());
                        default: add_random_store();
                    endcase
                end
                if (plan_fill == QUEUE_DEPTH)
                begin
                    for (i = $urandom_range(0, 2); i > 0; i--)
                        add_random_store();
                end
            end
            else if (r <= 4)
            begin
                while (plan_fill > 0)
                begin
                    case ($urandom_range(0, 7))
                        0: add_cmd(MODE_LIST, rand_code(), rand_prio());
                        1: add_random_store();
                        default: add_cmd(MODE_REMOVE, rand_code(), rand_prio());
                    endcase
                end
                for (i = $urandom_range(0, 2); i > 0; i--)
                    add_cmd($urandom_range(0, 1) ? MODE_LIST : MODE_REMOVE,
                            rand_code(), rand_prio());
            end
            else
            begin
                for (i = $urandom_range(3, 12); i > 0; i--)
                    add_cmd(2'($urandom_range(0, 3)), rand_code(), rand_prio());
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : sender
        int unsigned gap;
        logic        free;
        if (!rst_n)
        begin
            cmd_valid  <= 1'b0;
            cmd        <= '0;
            send_wait  <= 0;
            cmds_taken <= 0;
        end
        else
        begin
            gap  = send_wait;
            free = !cmd_valid;
            if (cmd_valid && !cmd_stall)
            begin
                shadow_queue_op(cmd);
                cmds_taken <= cmds_taken + 1;
                gap  = ((cmds_taken % 128) < 40) ? 0 : $urandom_range(0, 17);
                free = 1'b1;
            end
            if (free)
            begin
                if (gap == 0 && cmd_backlog.size() != 0)
                begin
                    cmd       <= cmd_backlog.pop_front();
                    cmd_valid <= 1'b1;
                    send_wait <= 0;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                    send_wait <= (gap == 0) ? 0 : gap - 1;
                end
            end
        end
    end

    // one long output hold so the unit backs up and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && cmds_taken >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver
        int unsigned wait_left;
        if (!rst_n)
        begin
            res_stall     <= 1'b0;
            rx_wait       <= 0;
            results_taken <= 0;
        end
        else
        begin
            wait_left = rx_wait;
            if (res_valid && !res_stall)
            begin
                check_result(res);
                results_taken <= results_taken + 1;
                wait_left = ((results_taken % 96) >= 64) ? 0 : $urandom_range(0, 17);
            end
            else if (wait_left != 0)
            begin
                wait_left = wait_left - 1;
            end
            rx_wait   <= wait_left;
            res_stall <= (wait_left != 0) || (hold_left != 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("stable_sorted_priority_queue_unit verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        build_stimulus();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (cmd_backlog.size() != 0 || cmd_valid || awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_replies.size() != 0)
            report_mismatch("results never delivered", 32'(awaited_replies.size()), 32'd0);
        if (mismatches == 0)
            $display("stable_sorted_priority_queue_unit verification clean");
        else
            $display("stable_sorted_priority_queue_unit verification failed");
        $finish;
    end

endmodule
